// ===== design/tsfg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsfg_pkg
// Shared widths, codes and divider request types for the star field block.
// ----------------------------------------------------------------------------
package tsfg_pkg;

	localparam int DATA_W    = 32;
	localparam int DIV_W     = 12;
	localparam int ACTION_W  = 2;
	localparam int COLUMN_W  = 4;
	localparam int ROW_W     = 6;
	localparam int COLOR_W   = 24;
	localparam int LEVEL_W   = 8;
	localparam int DENSITY_W = 5;
	localparam int INT_W     = 9;
	localparam int NUM_W     = 23;
	localparam int CFG_IDX_W = 3;

	// pixel grid, a power of two on each axis
	localparam int COLUMNS = 1 << COLUMN_W;
	localparam int ROWS    = 1 << ROW_W;

	localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DENS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEED  = 3'd5;

	localparam logic [DIV_W-1:0] LIFE_MIN  = 12'd500;
	localparam logic [DIV_W-1:0] LIFE_MAX  = 12'd4000;
	localparam logic [DIV_W-1:0] OFFS_SPAN = 12'd1500;
	localparam int               STARS_PER_DENSITY = 10;
	localparam logic [INT_W-1:0] INT_FULL  = 9'd256;
	localparam logic [NUM_W-1:0] RAMP_SCALE = 23'd1280;

	// r / 1500 = ((r >> 2) * OFFS_MAGIC) >> OFFS_SHIFT, exact for 32-bit r
	localparam int          OFFS_PROD_W = 61;
	localparam int          OFFS_SHIFT  = 39;
	localparam logic [30:0] OFFS_MAGIC  = 31'd1466015504;

	typedef struct packed {
		logic              go;
		logic [DATA_W-1:0] dividend;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DIV_W-1:0]  remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== design/tsfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsfg_if
// Request and result channels of the star field block (valid/ready).
// ----------------------------------------------------------------------------
interface tsfg_in_if;
	import tsfg_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [DATA_W-1:0]   now_time;
	logic [COLUMN_W-1:0] column;
	logic [ROW_W-1:0]    row;
	modport source (output valid, action, now_time, column, row, input ready);
	modport sink   (input valid, action, now_time, column, row, output ready);
endinterface

interface tsfg_out_if;
	import tsfg_pkg::*;
	logic               valid;
	logic               ready;
	logic               lit;
	logic [COLOR_W-1:0] pixel_color;
	modport source (output valid, lit, pixel_color, input ready);
	modport sink   (input valid, lit, pixel_color, output ready);
endinterface
`default_nettype wire

// ===== design/twinkling_star_field_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One item at a time; the sequencer takes a new item only while idle, and all
// steps share one serial divider and the single slot memory port. Reset: colour
// 255/255/255, density 5, speed 1, seed 1, time 0; slot contents are undefined
// until a start item writes them.
// ----------------------------------------------------------------------------
// twinkling_star_field_generator_core
// Star slot table in one synchronous memory, scanned by a sequencer that
// seeds, ages and looks up stars and shapes each colour by a trapezoid envelope.
// ----------------------------------------------------------------------------
module twinkling_star_field_generator_core #(
	parameter int STAR_SLOTS = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tsfg_in_if.sink                             item,
	tsfg_out_if.source                          result,
	input  wire logic                           cfg_we,
	input  wire logic [tsfg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsfg_pkg::DATA_W-1:0]    cfg_data
);
	import tsfg_pkg::*;

	// storage widths follow the geometry
	localparam int SLOT_W = (STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1;
	localparam int CNT_W  = $clog2(STAR_SLOTS + 1);
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [RW_W-1:0]   row;
		logic [DATA_W-1:0] start;
		logic [DIV_W-1:0]  life;
	} slot_t;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LO   = 4'd1;   // 500 / speed
	localparam logic [3:0] S_HI   = 4'd2;   // 4000 / speed
	localparam logic [3:0] S_RD   = 4'd3;   // address slot k
	localparam logic [3:0] S_CHK  = 4'd4;   // slot data back, decide
	localparam logic [3:0] S_OFFS = 4'd5;   // start offset, reciprocal product
	localparam logic [3:0] S_LIFE = 4'd6;   // lifetime draw
	localparam logic [3:0] S_COL  = 4'd7;   // column draw
	localparam logic [3:0] S_ROW  = 4'd8;   // row draw
	localparam logic [3:0] S_WR   = 4'd9;   // write slot back
	localparam logic [3:0] S_ENV  = 4'd10;  // envelope division
	localparam logic [3:0] S_OUT  = 4'd11;  // load result register
	localparam logic [3:0] S_OSUB = 4'd12;  // start offset, remainder

	// configuration
	logic [LEVEL_W-1:0]   red_q, green_q, blue_q, speed_q;
	logic [DENSITY_W-1:0] dens_q;

	// control and working registers
	logic [3:0]          state_q;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    n_q;
	logic [ACTION_W-1:0] act_q;
	logic [DATA_W-1:0]   now_q;
	logic [COLUMN_W-1:0] qcol_q;
	logic [ROW_W-1:0]    qrow_q;
	logic [DATA_W-1:0]   cur_time_q;
	logic [DATA_W-1:0]   rng_q;
	logic [DIV_W-1:0]    lo_q, hi_q;
	logic                go_q;
	logic [NUM_W-1:0]    num_q;
	logic [INT_W-1:0]    inten_q;
	logic                hit_q;
	slot_t               new_q;
	slot_t               rd_q;
	logic                res_valid_q;
	logic                res_lit_q;
	logic [COLOR_W-1:0]  res_color_q;
	logic [OFFS_PROD_W-1:0] offs_prod_q;

	slot_t mem [STAR_SLOTS];

	div_req_t div_req;
	div_rsp_t div_rsp;

	tsfg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next xorshift32 value
	function automatic logic [DATA_W-1:0] xs32(input logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] t;
		t = x ^ (x << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	logic [LEVEL_W-1:0] sp;
	logic [DIV_W-1:0]   span;
	logic [CNT_W-1:0]   n_calc;
	logic               mem_we;
	logic [SLOT_W-1:0]  addr;
	logic               more;
	logic               match;
	logic               expired;
	logic [DATA_W-1:0]  e;
	logic [DATA_W+2:0]  e5;
	logic [DIV_W+1:0]   life4;
	logic [DIV_W-1:0]   e_lo;
	logic [INT_W+LEVEL_W-1:0] r_mul, g_mul, b_mul;
	logic               res_free;
	logic [OFFS_PROD_W-1:0] offs_mul;
	logic [DATA_W-1:0]  offs_rem;

	assign sp     = (speed_q == '0) ? LEVEL_W'(1) : speed_q;
	assign span   = (hi_q > lo_q) ? (hi_q - lo_q) : DIV_W'(1);
	assign n_calc = (32'(dens_q) * STARS_PER_DENSITY > STAR_SLOTS) ? CNT_W'(STAR_SLOTS)
	              : CNT_W'(32'(dens_q) * STARS_PER_DENSITY);
	assign addr   = k_q[SLOT_W-1:0];
	assign more   = k_q < n_q;
	assign mem_we = (state_q == S_WR);

	// start offset: draw mod 1500 by reciprocal product, then one subtract
	assign offs_mul = rng_q[DATA_W-1:2] * OFFS_MAGIC;
	assign offs_rem = rng_q - DATA_W'(offs_prod_q[OFFS_PROD_W-1:OFFS_SHIFT])
	                        * DATA_W'(OFFS_SPAN);

	// slot checks on the registered read data
	assign match   = (32'(rd_q.col) == 32'(qcol_q)) && (32'(rd_q.row) == 32'(qrow_q));
	assign expired = {1'b0, cur_time_q} > ({1'b0, rd_q.start} + 33'(rd_q.life));
	assign e       = cur_time_q - rd_q.start;
	assign e5      = ({3'b0, e} << 2) + {3'b0, e};
	assign life4   = {rd_q.life, 2'b00};
	assign e_lo    = e[DIV_W-1:0];

	assign r_mul = red_q * inten_q;
	assign g_mul = green_q * inten_q;
	assign b_mul = blue_q * inten_q;

	assign res_free = !res_valid_q || result.ready;

	// divider operands come from the state; go is a registered pulse
	always_comb begin
		div_req.go       = go_q;
		div_req.dividend = rng_q;
		div_req.divisor  = DIV_W'(1);
		unique case (state_q)
			S_LO:   begin div_req.dividend = 32'(LIFE_MIN);  div_req.divisor = DIV_W'(sp); end
			S_HI:   begin div_req.dividend = 32'(LIFE_MAX);  div_req.divisor = DIV_W'(sp); end
			S_LIFE: div_req.divisor = span;
			S_ENV:  begin div_req.dividend = 32'(num_q); div_req.divisor = rd_q.life; end
			default: ;
		endcase
	end

	// slot memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr] <= new_q;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q       <= 8'd255;
			green_q     <= 8'd255;
			blue_q      <= 8'd255;
			dens_q      <= 5'd5;
			speed_q     <= 8'd1;
			rng_q       <= 32'd1;
			cur_time_q  <= '0;
			state_q     <= S_IDLE;
			k_q         <= '0;
			n_q         <= '0;
			act_q       <= ACT_NONE;
			now_q       <= '0;
			qcol_q      <= '0;
			qrow_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			go_q        <= 1'b0;
			num_q       <= '0;
			inten_q     <= '0;
			hit_q       <= 1'b0;
			new_q       <= '0;
			res_valid_q <= 1'b0;
			res_lit_q   <= 1'b0;
			res_color_q <= '0;
			offs_prod_q <= '0;
		end else begin
			go_q <= 1'b0;
			// the load state refills the register itself
			if (res_valid_q && result.ready && state_q != S_OUT)
				res_valid_q <= 1'b0;

			// register writes must arrive only while idle; the block itself does not enforce it
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RED:   red_q   <= cfg_data[LEVEL_W-1:0];
					REG_GREEN: green_q <= cfg_data[LEVEL_W-1:0];
					REG_BLUE:  blue_q  <= cfg_data[LEVEL_W-1:0];
					REG_DENS:  dens_q  <= cfg_data[DENSITY_W-1:0];
					REG_SPEED: speed_q <= cfg_data[LEVEL_W-1:0];
					REG_SEED:  rng_q   <= (cfg_data == '0) ? 32'd1 : cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						act_q  <= item.action;
						now_q  <= item.now_time;
						qcol_q <= item.column;
						qrow_q <= item.row;
						n_q    <= n_calc;
						k_q    <= '0;
						hit_q  <= 1'b0;
						unique case (item.action)
							ACT_START, ACT_TICK: begin
								cur_time_q <= item.now_time;
								go_q       <= 1'b1;
								state_q    <= S_LO;
							end
							ACT_QUERY: state_q <= S_RD;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_LO: if (div_rsp.done) begin
					lo_q    <= div_rsp.quotient[DIV_W-1:0];
					go_q    <= 1'b1;
					state_q <= S_HI;
				end
				S_HI: if (div_rsp.done) begin
					hi_q    <= div_rsp.quotient[DIV_W-1:0];
					state_q <= S_RD;
				end
				S_RD: begin
					priority if (!more) begin
						// scan finished; a query without a hit answers dark
						state_q <= (act_q == ACT_QUERY) ? S_OUT : S_IDLE;
						inten_q <= '0;
					end else if (act_q == ACT_START) begin
						rng_q   <= xs32(rng_q);
						state_q <= S_OFFS;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (act_q == ACT_TICK) begin
						if (expired) begin
							new_q.start <= cur_time_q;
							rng_q       <= xs32(rng_q);
							go_q        <= 1'b1;
							state_q     <= S_LIFE;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= S_RD;
						end
					end else if (match) begin
						hit_q <= 1'b1;
						// trapezoid: ramp up, flat top, ramp down
						priority if (rd_q.life == '0 || cur_time_q < rd_q.start) begin
							inten_q <= '0;
							state_q <= S_OUT;
						end else if (e5 < 35'(rd_q.life)) begin
							num_q   <= RAMP_SCALE * NUM_W'(e_lo);
							go_q    <= 1'b1;
							state_q <= S_ENV;
						end else if (e5 < 35'(life4)) begin
							inten_q <= INT_FULL;
							state_q <= S_OUT;
						end else if (e > 32'(rd_q.life)) begin
							inten_q <= '0;
							state_q <= S_OUT;
						end else begin
							num_q   <= RAMP_SCALE * NUM_W'(rd_q.life - e_lo);
							go_q    <= 1'b1;
							state_q <= S_ENV;
						end
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_OFFS: begin
					offs_prod_q <= offs_mul;
					state_q     <= S_OSUB;
				end
				S_OSUB: begin
					new_q.start <= now_q + offs_rem;
					rng_q       <= xs32(rng_q);
					go_q        <= 1'b1;
					state_q     <= S_LIFE;
				end
				S_LIFE: if (div_rsp.done) begin
					new_q.life <= lo_q + div_rsp.remainder;
					rng_q      <= xs32(rng_q);
					state_q    <= S_COL;
				end
				// grid sizes are powers of two: the draw's low bits are the remainder
				S_COL: begin
					new_q.col <= rng_q[COL_W-1:0];
					rng_q     <= xs32(rng_q);
					state_q   <= S_ROW;
				end
				S_ROW: begin
					new_q.row <= rng_q[RW_W-1:0];
					state_q   <= S_WR;
				end
				S_WR: begin
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_RD;
				end
				S_ENV: if (div_rsp.done) begin
					inten_q <= div_rsp.quotient[INT_W-1:0];
					state_q <= S_OUT;
				end
				S_OUT: if (res_free) begin
					res_valid_q <= 1'b1;
					res_lit_q   <= hit_q;
					res_color_q <= {r_mul[INT_W+LEVEL_W-2:LEVEL_W],
					                g_mul[INT_W+LEVEL_W-2:LEVEL_W],
					                b_mul[INT_W+LEVEL_W-2:LEVEL_W]};
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready         = (state_q == S_IDLE);
	assign result.valid       = res_valid_q;
	assign result.lit         = res_lit_q;
	assign result.pixel_color = res_color_q;

	// slot writes stay inside the stars in use
	a_wr_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (k_q < n_q))
		else $error("slot write beyond stars in use");

	// a result is only produced by the load state
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside load state");

	// the divider is never restarted while it counts
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.go |-> !div_rsp.busy)
		else $error("divider started while busy");

	// an unknown action leaves the sequencer idle
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.action == ACT_NONE) |=> (state_q == S_IDLE))
		else $error("unknown action left idle");

	// a dark answer never carries colour
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_lit_q) |-> (res_color_q == '0))
		else $error("colour on unlit pixel");

endmodule
`default_nettype wire

// ===== design/tsfg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsfg_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsfg_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tsfg_pkg::div_req_t req,
	output tsfg_pkg::div_rsp_t      rsp
);
	import tsfg_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DIV_W-1:0]  dvs_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           ge;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], ge};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire
